FILE: rtl/lpgz_pkg.sv
// ----------------------------------------------------------------------------
// lpgz_pkg
// Shared types and constants for the line point generator with depth.
// ----------------------------------------------------------------------------
package lpgz_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // action codes on the input channel
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_NEXT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP_Y,
    ST_PREP_X,
    ST_DIV_START,
    ST_DIV_MINOR,
    ST_DIV_DEPTH,
    ST_SWEEP,
    ST_LAST
  } state_t;

  typedef struct packed {
    logic load;       // latch endpoints, emit start point
    logic prep;       // set up a sweep along the axis below
    logic axis_x;     // 1: x-major sweep, 0: y-major sweep
    logic div_start;  // launch the shared divider
    logic div_depth;  // divider dividend is dz rather than the minor delta
    logic cap_minor;  // capture quotient/remainder for the minor coordinate
    logic cap_depth;  // capture quotient/remainder for depth
    logic step;       // advance one sweep point and emit it
    logic emit_end;   // emit the end point, flagged last
  } dp_cmd_t;

  typedef struct packed {
    logic y_zero;       // dy is zero: y sweep empty
    logic x_zero;       // dx is zero: x sweep empty
    logic div_done;     // divider result ready this cycle
    logic sweep_final;  // next step is the last of the sweep
    logic axis_x;       // current sweep is x-major
    logic out_busy;     // output register full and stalled
  } dp_status_t;

endpackage

FILE: rtl/lpgz_div.sv
// ----------------------------------------------------------------------------
// lpgz_div
// Iterative restoring divider, one quotient bit per cycle, floored result:
// signed dividend over positive divisor, nonnegative remainder.
// ----------------------------------------------------------------------------
module lpgz_div #(
  parameter int W = lpgz_pkg::COORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W:0]   dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W:0]   quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r;
  logic [W-1:0]  dvs_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  rem_r;

  logic [W:0]    dvd_neg;
  logic [W-1:0]  dvd_mag;
  logic [W:0]    trial;
  logic [W:0]    trial_sub;
  logic          qbit;
  logic [W:0]    qa;

  assign dvd_neg   = -dividend;
  assign dvd_mag   = dividend[W] ? dvd_neg[W-1:0] : dividend[W-1:0];
  assign trial     = {rem_r, quo_r[W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign qbit      = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + {{(CW-1){1'b0}}, 1'b1};
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[W];
      dvs_r <= divisor;
      quo_r <= dvd_mag;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[W-2:0], qbit};
      rem_r <= qbit ? trial_sub[W-1:0] : trial[W-1:0];
    end
  end

  // floor correction for a negative dividend
  assign qa = {1'b0, quo_r};

  always_comb begin
    if (neg_r && (rem_r != '0)) begin
      quot = ~qa;
      rem  = dvs_r - rem_r;
    end else if (neg_r) begin
      quot = -qa;
      rem  = rem_r;
    end else begin
      quot = qa;
      rem  = rem_r;
    end
  end

  assign done = done_r;

endmodule

FILE: rtl/lpgz_datapath.sv
// ----------------------------------------------------------------------------
// lpgz_datapath
// Endpoint store, sweep counters, remainder accumulators, shared divider
// and the output register.
// ----------------------------------------------------------------------------
module lpgz_datapath #(
  parameter int W = lpgz_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lpgz_pkg::dp_cmd_t    cmd,
  output lpgz_pkg::dp_status_t st,
  input  logic [W-1:0]         x_start,
  input  logic [W-1:0]         y_start,
  input  logic [W-1:0]         z_start,
  input  logic [W-1:0]         x_end,
  input  logic [W-1:0]         y_end,
  input  logic [W-1:0]         z_end,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [W-1:0]         point_x,
  output logic [W-1:0]         point_y,
  output logic [W-1:0]         point_z,
  output logic                 last_point
);

  logic [W-1:0] xs_r, ys_r, zs_r, xe_r, ye_r, ze_r;
  logic [W-1:0] cx_r, cy_r, cz_r;
  logic [W-1:0] n_r, idx_r;
  logic         axis_x_r;
  logic         dir_neg_r;
  logic [W:0]   q0_r, q1_r;
  logic [W-1:0] r0_r, r1_r, a0_r, a1_r;
  logic         out_valid_r;
  logic [W-1:0] ox_r, oy_r, oz_r;
  logic         olast_r;

  logic [W:0]   dx, dy, dz, dx_neg, dy_neg;
  logic [W-1:0] abs_x, abs_y;
  logic [W:0]   div_dvd;
  logic         div_done;
  logic [W:0]   div_quot;
  logic [W-1:0] div_rem;
  logic [W-1:0] idx_inc;
  logic [W:0]   sum0, sum1, sub0, sub1;
  logic         c0, c1;
  logic [W-1:0] a0_nxt, a1_nxt;
  logic [W-1:0] minor_cur, minor_nxt, major_cur, major_nxt, z_nxt;
  logic [W-1:0] step_x, step_y;

  assign dx     = {xe_r[W-1], xe_r} - {xs_r[W-1], xs_r};
  assign dy     = {ye_r[W-1], ye_r} - {ys_r[W-1], ys_r};
  assign dz     = {ze_r[W-1], ze_r} - {zs_r[W-1], zs_r};
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign abs_x  = dx[W] ? dx_neg[W-1:0] : dx[W-1:0];
  assign abs_y  = dy[W] ? dy_neg[W-1:0] : dy[W-1:0];

  assign div_dvd = cmd.div_depth ? dz : (axis_x_r ? dy : dx);

  lpgz_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (n_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // carry one unit whenever the accumulator reaches the sweep length
  assign sum0   = {1'b0, a0_r} + {1'b0, r0_r};
  assign sum1   = {1'b0, a1_r} + {1'b0, r1_r};
  assign sub0   = sum0 - {1'b0, n_r};
  assign sub1   = sum1 - {1'b0, n_r};
  assign c0     = (sum0 >= {1'b0, n_r});
  assign c1     = (sum1 >= {1'b0, n_r});
  assign a0_nxt = c0 ? sub0[W-1:0] : sum0[W-1:0];
  assign a1_nxt = c1 ? sub1[W-1:0] : sum1[W-1:0];

  assign minor_cur = axis_x_r ? cy_r : cx_r;
  assign major_cur = axis_x_r ? cx_r : cy_r;
  assign minor_nxt = minor_cur + q0_r[W-1:0] + {{(W-1){1'b0}}, c0};
  assign z_nxt     = cz_r + q1_r[W-1:0] + {{(W-1){1'b0}}, c1};
  assign major_nxt = dir_neg_r ? major_cur - {{(W-1){1'b0}}, 1'b1}
                               : major_cur + {{(W-1){1'b0}}, 1'b1};
  assign step_x    = axis_x_r ? major_nxt : minor_nxt;
  assign step_y    = axis_x_r ? minor_nxt : major_nxt;

  assign idx_inc = idx_r + {{(W-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_r <= x_start;
      ys_r <= y_start;
      zs_r <= z_start;
      xe_r <= x_end;
      ye_r <= y_end;
      ze_r <= z_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r <= 1'b0;
      idx_r    <= '0;
    end else if (cmd.prep) begin
      axis_x_r <= cmd.axis_x;
      idx_r    <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= x_start;
      cy_r <= y_start;
      cz_r <= z_start;
    end else if (cmd.prep) begin
      // restart from the start point for each sweep
      cx_r      <= xs_r;
      cy_r      <= ys_r;
      cz_r      <= zs_r;
      n_r       <= cmd.axis_x ? abs_x : abs_y;
      dir_neg_r <= cmd.axis_x ? dx[W] : dy[W];
    end else if (cmd.step) begin
      cx_r <= step_x;
      cy_r <= step_y;
      cz_r <= z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_minor) begin
      q0_r <= div_quot;
      r0_r <= div_rem;
      a0_r <= '0;
    end else if (cmd.step) begin
      a0_r <= a0_nxt;
    end
    if (cmd.cap_depth) begin
      q1_r <= div_quot;
      r1_r <= div_rem;
      a1_r <= '0;
    end else if (cmd.step) begin
      a1_r <= a1_nxt;
    end
  end

  // output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load || cmd.step || cmd.emit_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ox_r    <= x_start;
      oy_r    <= y_start;
      oz_r    <= z_start;
      olast_r <= 1'b0;
    end else if (cmd.step) begin
      ox_r    <= step_x;
      oy_r    <= step_y;
      oz_r    <= z_nxt;
      olast_r <= 1'b0;
    end else if (cmd.emit_end) begin
      ox_r    <= xe_r;
      oy_r    <= ye_r;
      oz_r    <= ze_r;
      olast_r <= 1'b1;
    end
  end

  assign st.y_zero      = (dy == '0);
  assign st.x_zero      = (dx == '0);
  assign st.div_done    = div_done;
  assign st.sweep_final = (idx_inc == n_r);
  assign st.axis_x      = axis_x_r;
  assign st.out_busy    = out_valid_r && out_stall;

  assign out_valid  = out_valid_r;
  assign point_x    = ox_r;
  assign point_y    = oy_r;
  assign point_z    = oz_r;
  assign last_point = olast_r;

endmodule

FILE: rtl/lpgz_ctrl.sv
// ----------------------------------------------------------------------------
// lpgz_ctrl
// Sequencer: accepts transactions, runs sweep set-up through the divider
// and steps the sweeps.
// ----------------------------------------------------------------------------
module lpgz_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_action,
  output logic                 in_stall,
  input  lpgz_pkg::dp_status_t st,
  output lpgz_pkg::dp_cmd_t    cmd
);

  lpgz_pkg::state_t state_r, state_nxt;
  logic             in_ready;
  logic             take;

  assign take     = in_valid && in_ready;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpgz_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      lpgz_pkg::ST_IDLE: begin
        // a next-point request with no line is taken and dropped
        in_ready = !st.out_busy;
        if (take && (in_action == lpgz_pkg::ACT_LOAD)) begin
          cmd.load  = 1'b1;
          state_nxt = lpgz_pkg::ST_PREP_Y;
        end
      end
      lpgz_pkg::ST_PREP_Y: begin
        if (st.y_zero) begin
          state_nxt = lpgz_pkg::ST_PREP_X;
        end else begin
          cmd.prep   = 1'b1;
          cmd.axis_x = 1'b0;
          state_nxt  = lpgz_pkg::ST_DIV_START;
        end
      end
      lpgz_pkg::ST_PREP_X: begin
        if (st.x_zero) begin
          state_nxt = lpgz_pkg::ST_LAST;
        end else begin
          cmd.prep   = 1'b1;
          cmd.axis_x = 1'b1;
          state_nxt  = lpgz_pkg::ST_DIV_START;
        end
      end
      lpgz_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = lpgz_pkg::ST_DIV_MINOR;
      end
      lpgz_pkg::ST_DIV_MINOR: begin
        if (st.div_done) begin
          cmd.cap_minor = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_depth = 1'b1;
          state_nxt     = lpgz_pkg::ST_DIV_DEPTH;
        end
      end
      lpgz_pkg::ST_DIV_DEPTH: begin
        if (st.div_done) begin
          cmd.cap_depth = 1'b1;
          state_nxt     = lpgz_pkg::ST_SWEEP;
        end
      end
      lpgz_pkg::ST_SWEEP: begin
        in_ready = !st.out_busy;
        if (take) begin
          if (in_action == lpgz_pkg::ACT_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = lpgz_pkg::ST_PREP_Y;
          end else begin
            cmd.step = 1'b1;
            if (st.sweep_final) begin
              state_nxt = st.axis_x ? lpgz_pkg::ST_LAST : lpgz_pkg::ST_PREP_X;
            end
          end
        end
      end
      lpgz_pkg::ST_LAST: begin
        in_ready = !st.out_busy;
        if (take) begin
          if (in_action == lpgz_pkg::ACT_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = lpgz_pkg::ST_PREP_Y;
          end else begin
            cmd.emit_end = 1'b1;
            state_nxt    = lpgz_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lpgz_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/line_point_generator_z_interp_unit.sv
// A result appears in the output register in the cycle after its transaction is taken.
// Throughput: one point per cycle along a sweep while the output is taken.
// After a load, and again between the y sweep and the x sweep, the input stalls while
// two floored divisions run on one shared bit-serial divider.
// Reset (rst_n low, synchronous): no line loaded, output register empty.
// ----------------------------------------------------------------------------
// line_point_generator_z_interp_unit
// Line point generator with exact floored depth and minor-axis interpolation.
// ----------------------------------------------------------------------------
module line_point_generator_z_interp_unit #(
  parameter int COORD_WIDTH = lpgz_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic signed [COORD_WIDTH-1:0] in_x_start,
  input  logic signed [COORD_WIDTH-1:0] in_y_start,
  input  logic signed [COORD_WIDTH-1:0] in_z_start,
  input  logic signed [COORD_WIDTH-1:0] in_x_end,
  input  logic signed [COORD_WIDTH-1:0] in_y_end,
  input  logic signed [COORD_WIDTH-1:0] in_z_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y,
  output logic signed [COORD_WIDTH-1:0] out_point_z,
  output logic                          out_last_point
);

  lpgz_pkg::dp_cmd_t    cmd;
  lpgz_pkg::dp_status_t st;
  logic [COORD_WIDTH-1:0] px, py, pz;

  lpgz_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .st        (st),
    .cmd       (cmd)
  );

  lpgz_datapath #(.W(COORD_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .x_start    (in_x_start),
    .y_start    (in_y_start),
    .z_start    (in_z_start),
    .x_end      (in_x_end),
    .y_end      (in_y_end),
    .z_end      (in_z_end),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .point_x    (px),
    .point_y    (py),
    .point_z    (pz),
    .last_point (out_last_point)
  );

  assign out_point_x = px;
  assign out_point_y = py;
  assign out_point_z = pz;

endmodule

FILE: bench/tb_line_point_generator_z_interp_unit.sv
// ----------------------------------------------------------------------------
// Line point generator testbench
// Loads lines and requests their points one by one. A built-in predictor works
// out every point, including the exactly floored minor coordinate and depth, and
// a checker compares each point that leaves the block against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_point_generator_z_interp_unit;

  localparam int CW = lpgz_pkg::COORD_WIDTH_DEF;
  localparam longint C_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint C_MIN = -C_MAX - 1;
  localparam int RAND_ITEMS = 1300;
  localparam int IDLE_LIMIT = 2000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } point_t;

  typedef enum logic [1:0] {SW_IDLE, SW_Y, SW_X, SW_END} sweep_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   in_action = lpgz_pkg::ACT_NEXT;
  coord_t in_x_start = '0;
  coord_t in_y_start = '0;
  coord_t in_z_start = '0;
  coord_t in_x_end = '0;
  coord_t in_y_end = '0;
  coord_t in_z_end = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_point_x;
  coord_t out_point_y;
  coord_t out_point_z;
  logic   out_last_point;

  // predictor state
  sweep_t sweep = SW_IDLE;
  longint p0_x, p0_y, p0_z, p1_x, p1_y, p1_z;
  longint step_cnt, sweep_len;
  longint minor_q, minor_r, minor_acc, minor_off;
  longint depth_q, depth_r, depth_acc, depth_off;

  point_t pending_points[$];
  point_t want_pt;
  bit     gaps_on = 1'b1;
  int     errors = 0;
  int     items_done = 0;
  int     lines_loaded = 0;
  int     points_checked = 0;
  int     idle_cycles = 0;

  line_point_generator_z_interp_unit #(
    .COORD_WIDTH(CW)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_z_start    (in_z_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .in_z_end      (in_z_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_point_z   (out_point_z),
    .out_last_point(out_last_point)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void split_floor(input longint num, input longint den,
                                      output longint q, output longint r);
    q = num / den;
    r = num % den;
    if (r < 0) begin
      r += den;
      q -= 1;
    end
  endfunction

  function automatic void bump(inout longint off, inout longint acc,
                               input longint q, input longint r);
    off += q;
    acc += r;
    if (acc >= sweep_len) begin
      acc -= sweep_len;
      off += 1;
    end
  endfunction

  // pick the first non-empty sweep from the given one onward
  function automatic void open_sweep(input sweep_t from);
    longint ny, nx;
    ny = mag(p1_y - p0_y);
    nx = mag(p1_x - p0_x);
    step_cnt = 0;
    minor_acc = 0;
    minor_off = 0;
    depth_acc = 0;
    depth_off = 0;
    if (from == SW_Y && ny > 0) begin
      sweep = SW_Y;
      sweep_len = ny;
      split_floor(p1_x - p0_x, ny, minor_q, minor_r);
      split_floor(p1_z - p0_z, ny, depth_q, depth_r);
    end else if (nx > 0) begin
      sweep = SW_X;
      sweep_len = nx;
      split_floor(p1_y - p0_y, nx, minor_q, minor_r);
      split_floor(p1_z - p0_z, nx, depth_q, depth_r);
    end else begin
      sweep = SW_END;
    end
  endfunction

  function automatic bit predict_point(input logic act, input coord_t xs, input coord_t ys,
                                       input coord_t zs, input coord_t xe, input coord_t ye,
                                       input coord_t ze, output point_t pt);
    pt = '0;
    if (act == lpgz_pkg::ACT_LOAD) begin
      p0_x = xs;
      p0_y = ys;
      p0_z = zs;
      p1_x = xe;
      p1_y = ye;
      p1_z = ze;
      pt = '{x: xs, y: ys, z: zs, last: 1'b0};
      open_sweep(SW_Y);
      return 1'b1;
    end
    case (sweep)
      SW_END: begin
        pt = '{x: coord_t'(p1_x), y: coord_t'(p1_y), z: coord_t'(p1_z), last: 1'b1};
        sweep = SW_IDLE;
        return 1'b1;
      end
      SW_Y: begin
        step_cnt += 1;
        bump(minor_off, minor_acc, minor_q, minor_r);
        bump(depth_off, depth_acc, depth_q, depth_r);
        pt.x = coord_t'(p0_x + minor_off);
        pt.y = coord_t'((p1_y > p0_y) ? p0_y + step_cnt : p0_y - step_cnt);
        pt.z = coord_t'(p0_z + depth_off);
        if (step_cnt >= sweep_len) open_sweep(SW_X);
        return 1'b1;
      end
      SW_X: begin
        step_cnt += 1;
        bump(minor_off, minor_acc, minor_q, minor_r);
        bump(depth_off, depth_acc, depth_q, depth_r);
        pt.x = coord_t'((p1_x > p0_x) ? p0_x + step_cnt : p0_x - step_cnt);
        pt.y = coord_t'(p0_y + minor_off);
        pt.z = coord_t'(p0_z + depth_off);
        if (step_cnt >= sweep_len) sweep = SW_END;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ------------------------------------------------------------------ driving
  function automatic coord_t rnd_coord();
    return coord_t'($urandom);
  endfunction

  // endpoint a few units from base, mirrored when it would leave the range
  function automatic coord_t near(input coord_t base, input int span);
    longint d, e;
    d = ($urandom_range(3) == 0) ? 0 : longint'($urandom_range(2 * span)) - span;
    e = base + d;
    if (e > C_MAX || e < C_MIN) e = base - d;
    return coord_t'(e);
  endfunction

  // called just after a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the caller decides what comes next
  task automatic issue_item(input logic act, input coord_t xs, input coord_t ys,
                            input coord_t zs, input coord_t xe, input coord_t ye,
                            input coord_t ze);
    point_t pt;
    bit     made;
    while (gaps_on && $urandom_range(99) < 13) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_action  = act;
    in_x_start = xs;
    in_y_start = ys;
    in_z_start = zs;
    in_x_end   = xe;
    in_y_end   = ye;
    in_z_end   = ze;
    do @(posedge clk); while (in_stall);
    made = predict_point(act, xs, ys, zs, xe, ye, ze, pt);
    if (made) pending_points.push_back(pt);
    if (made || act == lpgz_pkg::ACT_LOAD) items_done++;
    if (act == lpgz_pkg::ACT_LOAD) lines_loaded++;
    @(negedge clk);
  endtask

  task automatic load_line(input coord_t xs, input coord_t ys, input coord_t zs,
                           input coord_t xe, input coord_t ye, input coord_t ze);
    issue_item(lpgz_pkg::ACT_LOAD, xs, ys, zs, xe, ye, ze);
  endtask

  // the coordinate fields of a request are don't-care: fill them with noise
  task automatic next_point();
    issue_item(lpgz_pkg::ACT_NEXT, rnd_coord(), rnd_coord(), rnd_coord(),
               rnd_coord(), rnd_coord(), rnd_coord());
  endtask

  task automatic finish_line();
    while (sweep != SW_IDLE) next_point();
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  task automatic random_short_line(input int span);
    coord_t xs, ys, zs;
    xs = rnd_coord();
    ys = rnd_coord();
    zs = rnd_coord();
    load_line(xs, ys, zs, near(xs, span), near(ys, span),
              $urandom_range(1) ? rnd_coord() : near(zs, 20));
  endtask

  // receiver side
  always @(negedge clk) out_stall <= gaps_on && ($urandom_range(99) < 13);

  // ------------------------------------------------------------------ checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point x=%0d y=%0d z=%0d last=%0b",
               out_point_x, out_point_y, out_point_z, out_last_point);
        errors++;
      end else begin
        want_pt = pending_points.pop_front();
        points_checked++;
        if (out_point_x !== want_pt.x) begin
          $error("point_x: expected %0d, got %0d", want_pt.x, out_point_x);
          errors++;
        end
        if (out_point_y !== want_pt.y) begin
          $error("point_y: expected %0d, got %0d", want_pt.y, out_point_y);
          errors++;
        end
        if (out_point_z !== want_pt.z) begin
          $error("point_z: expected %0d, got %0d", want_pt.z, out_point_z);
          errors++;
        end
        if (out_last_point !== want_pt.last) begin
          $error("last_point: expected %0b, got %0b", want_pt.last, out_last_point);
          errors++;
        end
      end
    end
  end

  // end the run when no transaction moves on either side for too long
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // -------------------------------------------------------------------- tests
  task automatic test_no_line_requests();
    next_point();
    next_point();
  endtask

  task automatic test_degenerate_lines();
    load_line(coord_t'(C_MIN), coord_t'(C_MIN), coord_t'(C_MIN),
              coord_t'(C_MIN), coord_t'(C_MIN), coord_t'(C_MIN));
    finish_line();
    load_line(coord_t'(C_MAX), coord_t'(C_MAX), coord_t'(C_MAX),
              coord_t'(C_MAX), coord_t'(C_MAX), coord_t'(C_MAX));
    finish_line();
    // request past the end of the line: ignored
    next_point();
  endtask

  // full-range spans are far too long to finish: take a few points, then reload
  task automatic test_extreme_spans();
    load_line(coord_t'(C_MIN), coord_t'(C_MAX), coord_t'(C_MIN),
              coord_t'(C_MAX), coord_t'(C_MIN), coord_t'(C_MAX));
    repeat (3) next_point();
    load_line(coord_t'(C_MAX), coord_t'(5), coord_t'(C_MAX),
              coord_t'(C_MIN), coord_t'(5), coord_t'(C_MIN));
    repeat (3) next_point();
  endtask

  task automatic test_steep_depth();
    load_line(coord_t'(C_MAX - 2), coord_t'(C_MIN), coord_t'(C_MIN),
              coord_t'(C_MAX), coord_t'(C_MIN + 1), coord_t'(C_MAX));
    finish_line();
  endtask

  task automatic test_drain_pause();
    random_short_line(6);
    finish_line();
    wait_drained();
    random_short_line(6);
    finish_line();
  endtask

  task automatic test_random_lines();
    int     pick;
    longint dy_abs;
    coord_t ys, ye;
    while (items_done < RAND_ITEMS) begin
      // hold a stretch with no idling on either side
      gaps_on = (items_done < 500 || items_done >= 750);
      pick = $urandom_range(99);
      if (pick < 75) begin
        random_short_line($urandom_range(1, 12));
        finish_line();
      end else if (pick < 84) begin
        load_line(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        repeat ($urandom_range(1, 6)) next_point();
      end else if (pick < 92) begin
        // short y span, long x span: abandon inside the x sweep
        ys = rnd_coord();
        ye = near(ys, 2);
        dy_abs = mag(longint'(ye) - longint'(ys));
        load_line(rnd_coord(), ys, rnd_coord(), rnd_coord(), ye, rnd_coord());
        repeat (int'(dy_abs) + $urandom_range(1, 5)) next_point();
      end else if (pick < 97) begin
        random_short_line($urandom_range(1, 8));
        repeat ($urandom_range(0, 3)) next_point();
      end else begin
        // run a short line to its end, then ask past it
        random_short_line($urandom_range(1, 6));
        finish_line();
        repeat ($urandom_range(1, 3)) next_point();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_no_line_requests();
    test_degenerate_lines();
    test_extreme_spans();
    test_steep_depth();
    test_drain_pause();
    test_random_lines();
    wait_drained();
    repeat (4) @(posedge clk);
    $display("Ran %0d lines and %0d transactions; %0d points checked, %0d errors.",
             lines_loaded, items_done, points_checked, errors);
    $display("Lines spanned full-range, degenerate, abandoned and short steep cases.");
    if (errors == 0 && pending_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
